// ===== src/ttad_pkg.sv =====
// Shared types and constants for the teletext serial attribute decoder.
// Holds the control code map and the attribute record; no dependencies.
package ttad_pkg;

	// Serial attribute control codes (low five bits of a cell byte below 0x20)
	localparam logic [4:0] CODE_BLACK_BG     = 5'h00;
	localparam logic [4:0] CODE_ALPHA_LO     = 5'h01;
	localparam logic [4:0] CODE_ALPHA_HI     = 5'h07;
	localparam logic [4:0] CODE_FLASH        = 5'h08;
	localparam logic [4:0] CODE_STEADY       = 5'h09;
	localparam logic [4:0] CODE_NORMAL_SIZE  = 5'h0C;
	localparam logic [4:0] CODE_DOUBLE_HT    = 5'h0D;
	localparam logic [4:0] CODE_MOSAIC_LO    = 5'h10;
	localparam logic [4:0] CODE_MOSAIC_HI    = 5'h17;
	localparam logic [4:0] CODE_CONCEAL      = 5'h18;
	localparam logic [4:0] CODE_BLACK_BG_ALT = 5'h1C;
	localparam logic [4:0] CODE_NEW_BG       = 5'h1D;
	localparam logic [4:0] CODE_HOLD         = 5'h1E;
	localparam logic [4:0] CODE_RELEASE      = 5'h1F;

	localparam logic [6:0] SPACE_GLYPH = 7'h20;
	localparam logic [5:0] FLASH_LIMIT = 6'd38;
	localparam logic [2:0] FG_DEFAULT  = 3'd7;
	localparam logic [2:0] BG_DEFAULT  = 3'd0;
	localparam logic [2:0] BG_WHITE    = 3'd7;
	localparam logic [4:0] VARIANT_ROW = 5'd3;

	// Serial attributes that column 0 resets
	typedef struct packed {
		logic [2:0] fg;
		logic [2:0] bg;
		logic       graphics;
		logic       flash;
		logic       tall;
		logic       conceal;
		logic [6:0] held;
	} attr_t;

	localparam attr_t ATTR_ROW_START = '{
		fg:       FG_DEFAULT,
		bg:       BG_DEFAULT,
		graphics: 1'b0,
		flash:    1'b0,
		tall:     1'b0,
		conceal:  1'b0,
		held:     SPACE_GLYPH
	};

endpackage

// ===== src/teletext_attribute_decoder.sv =====
// Teletext serial attribute decoder: top level, one cell word in, one decoded cell out.
// Depends on ttad_pkg for control codes and the attribute record.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one cell word: char_byte, row, column,
//   frame_phase. Output channel (out_valid/out_ready) carries the decoded cell:
//   glyph, colours, mosaic and double-height flags, and its row and column.
//   cfg_wr_en/cfg_wr_data write second_variant; write only while the block is idle.
// Path: a word accepted into the input register is decoded against the attribute
//   state, and its result is registered in the result stage, where it drives the
//   output and holds while out_ready is low.
// Throughput: one word per cycle unless out_ready stalls the output. The decode of
//   a word and the attribute update are combinational, between input and result registers.
// Words off the page, words of a skipped row and the column 0 word that starts
//   a skipped row produce no result.
// Reset: attributes go to white on black, all flags off, held glyph space, no row
//   skip pending, second_variant cleared; both pipeline stages empty.
// Stall: while out_ready is low a result holds; the input register still takes one
//   more word, then in_ready drops until the result is taken.
module teletext_attribute_decoder
	import ttad_pkg::*;
#(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 42
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic [4:0] row,
	input  logic [5:0] column,
	input  logic [5:0] frame_phase,

	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] glyph,
	output logic [2:0] fg_colour,
	output logic [2:0] bg_colour,
	output logic       mosaic_glyph,
	output logic       double_height,
	output logic [4:0] out_row,
	output logic [5:0] out_column
);

	// Input stage
	logic       valid_s1;
	logic [6:0] char_s1;
	logic [4:0] row_s1;
	logic [5:0] column_s1;
	logic [5:0] phase_s1;

	// Decoder state
	logic       second_variant_q;
	attr_t      attr_q;
	logic [6:0] prev_glyph_q;
	logic       skip_pending_q;
	logic       skipping_row_q;

	// Result stage
	logic       valid_s2;
	logic [6:0] glyph_s2;
	logic [2:0] fg_s2;
	logic [2:0] bg_s2;
	logic       mosaic_s2;
	logic       tall_s2;
	logic [4:0] row_s2;
	logic [5:0] column_s2;

	logic       s2_free;
	logic       advance;
	logic       on_page;
	logic       emit_c;
	logic       row3_variant;
	logic [4:0] code;
	attr_t      attr_n;
	logic [6:0] glyph_n;
	logic [6:0] prev_glyph_n;
	logic       skip_pending_n;
	logic       skipping_row_n;

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	assign on_page = ({1'b0, row_s1} < 6'(ROWS)) && ({1'b0, column_s1} < 7'(COLUMNS));
	assign row3_variant = second_variant_q && (row_s1 == VARIANT_ROW);
	assign code = char_s1[4:0];

	always_comb begin
		attr_n         = attr_q;
		prev_glyph_n   = prev_glyph_q;
		skip_pending_n = skip_pending_q;
		skipping_row_n = skipping_row_q;
		glyph_n        = char_s1;
		emit_c         = 1'b0;

		if (on_page) begin
			emit_c = 1'b1;
			if (column_s1 == '0) begin
				// a page starts at row 0, so no skip carries into it
				if (row_s1 == '0)
					skip_pending_n = 1'b0;
				if (skip_pending_n) begin
					skip_pending_n = 1'b0;
					skipping_row_n = 1'b1;
					emit_c         = 1'b0;
				end else begin
					skipping_row_n = 1'b0;
					attr_n         = ATTR_ROW_START;
				end
			end else if (skipping_row_q) begin
				emit_c = 1'b0;
			end
		end

		if (emit_c) begin
			if (char_s1[6:5] == 2'b00) begin
				unique case (code) inside
					[CODE_ALPHA_LO:CODE_ALPHA_HI]: begin
						attr_n.graphics = 1'b0;
						attr_n.fg       = code[2:0];
						attr_n.conceal  = 1'b0;
					end
					[CODE_MOSAIC_LO:CODE_MOSAIC_HI]: begin
						attr_n.graphics = 1'b1;
						attr_n.fg       = code[2:0];
						attr_n.conceal  = 1'b0;
					end
					CODE_BLACK_BG, CODE_BLACK_BG_ALT: attr_n.bg = BG_DEFAULT;
					CODE_FLASH:       attr_n.flash = 1'b1;
					CODE_STEADY:      attr_n.flash = 1'b0;
					CODE_NORMAL_SIZE: attr_n.tall  = 1'b0;
					CODE_DOUBLE_HT: begin
						attr_n.tall    = 1'b1;
						skip_pending_n = 1'b1;
						if (row3_variant)
							attr_n.bg = BG_WHITE;
					end
					CODE_CONCEAL: attr_n.conceal = 1'b1;
					CODE_NEW_BG: begin
						if (!row3_variant)
							attr_n.bg = attr_n.fg;
					end
					CODE_HOLD:    attr_n.held = prev_glyph_q;
					CODE_RELEASE: attr_n.held = SPACE_GLYPH;
					default: ;
				endcase
				glyph_n = attr_n.held;
			end
			// blank concealed cells and flashing cells in the off phase
			if (attr_n.conceal || (attr_n.flash && (phase_s1 > FLASH_LIMIT)))
				glyph_n = SPACE_GLYPH;
			prev_glyph_n = glyph_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_variant_q <= 1'b0;
		end else if (cfg_wr_en) begin
			second_variant_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1   <= char_byte[6:0];
			row_s1    <= row;
			column_s1 <= column;
			phase_s1  <= frame_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q         <= ATTR_ROW_START;
			prev_glyph_q   <= '0;
			skip_pending_q <= 1'b0;
			skipping_row_q <= 1'b0;
		end else if (advance) begin
			attr_q         <= attr_n;
			prev_glyph_q   <= prev_glyph_n;
			skip_pending_q <= skip_pending_n;
			skipping_row_q <= skipping_row_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit_c;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_c) begin
			glyph_s2  <= glyph_n;
			fg_s2     <= attr_n.fg;
			bg_s2     <= attr_n.bg;
			mosaic_s2 <= attr_n.graphics && glyph_n[5];
			tall_s2   <= attr_n.tall;
			row_s2    <= row_s1;
			column_s2 <= column_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign glyph         = glyph_s2;
	assign fg_colour     = fg_s2;
	assign bg_colour     = bg_s2;
	assign mosaic_glyph  = mosaic_s2;
	assign double_height = tall_s2;
	assign out_row       = row_s2;
	assign out_column    = column_s2;

	// A word inside a skipped row never reaches the output
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && skipping_row_q && (column_s1 != '0) |=> !out_valid)
		else $error("result produced for a skipped row");

	// A printable cell at column 0 shows the row-start colours
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit_c && (column_s1 == '0) && (char_s1[6:5] != 2'b00)
		|=> out_valid && (fg_colour == FG_DEFAULT) && (bg_colour == BG_DEFAULT))
		else $error("attributes not reset at start of row");

	// Mosaic font is only chosen for glyphs with bit 5 set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mosaic_glyph |-> glyph[5])
		else $error("mosaic flag on a glyph without bit 5");

	// Input back-pressure only comes from a full pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

endmodule
